// ----- design/nrd_pkg.sv -----
// Shared types, constants and fixed-point helpers for the nutation rotation block.
package nrd_pkg;

	localparam int FRAC_BITS = 46;
	localparam int FIX_W     = 48;
	localparam int HALF_W    = FIX_W / 2;
	localparam int OBL_W     = 47;
	localparam int NUT_W     = 38;
	localparam int CFG_W     = 47;
	localparam int IDX_W     = 2;
	localparam int PROD_W    = 2 * FIX_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int NARROW_W  = FIX_W + 2;

	typedef logic signed [FIX_W-1:0]    fix_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [NARROW_W-1:0] narrow_t;

	localparam fix_t FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
	localparam fix_t FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};
	localparam fix_t ONE = (FRAC_BITS >= FIX_W - 1) ? FIX_MAX : (fix_t'(1) <<< FRAC_BITS);
	localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
	localparam logic [OBL_W-1:0] COS_RESET = OBL_W'(1) << FRAC_BITS;

	typedef enum logic [IDX_W-1:0] {
		REG_COS  = 2'd0,
		REG_SIN  = 2'd1,
		REG_DPSI = 2'd2,
		REG_DEPS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		fix_t x;
		fix_t y;
		fix_t z;
	} vec_t;

	typedef struct packed {
		fix_t c0;
		fix_t c1;
		fix_t c2;
	} row_t;

	typedef struct packed {
		row_t r0;
		row_t r1;
		row_t r2;
	} matrix_t;

	typedef struct packed {
		logic pp_en;
		logic prod_en;
	} mul_en_t;

	typedef struct packed {
		mul_en_t mul;
		logic    acc_en;
		logic    out_en;
	} dot_en_t;

	function automatic fix_t sat_acc(input acc_t v);
		fix_t r;
		if (v > acc_t'(FIX_MAX)) begin
			r = FIX_MAX;
		end else if (v < acc_t'(FIX_MIN)) begin
			r = FIX_MIN;
		end else begin
			r = v[FIX_W-1:0];
		end
		return r;
	endfunction

	function automatic fix_t sat_narrow(input narrow_t v);
		fix_t r;
		if (v > narrow_t'(FIX_MAX)) begin
			r = FIX_MAX;
		end else if (v < narrow_t'(FIX_MIN)) begin
			r = FIX_MIN;
		end else begin
			r = v[FIX_W-1:0];
		end
		return r;
	endfunction

	// Round half up at the given binary point, then clamp to the fixed-point range.
	function automatic fix_t round_sat(input acc_t v, input int unsigned sh);
		acc_t half;
		acc_t sum;
		acc_t shr;
		half = acc_t'(1) <<< (sh - 1);
		sum  = v + half;
		shr  = sum >>> sh;
		return sat_acc(shr);
	endfunction

endpackage

// ----- design/nrd_mul.sv -----
// Two-stage exact signed 48x48 multiplier built from four narrow partial products.
module nrd_mul (
	input  logic              clk,
	input  nrd_pkg::mul_en_t  en,
	input  nrd_pkg::fix_t     a,
	input  nrd_pkg::fix_t     b,
	output nrd_pkg::prod_t    prod
);

	localparam int HW = nrd_pkg::HALF_W;

	logic signed [HW-1:0]   a_hi;
	logic signed [HW-1:0]   b_hi;
	logic signed [HW:0]     a_lo;
	logic signed [HW:0]     b_lo;
	logic signed [2*HW-1:0] hh;
	logic signed [2*HW:0]   hl;
	logic signed [2*HW:0]   lh;
	logic signed [2*HW-1:0] ll;

	logic signed [2*HW-1:0] hh_s1;
	logic signed [2*HW:0]   hl_s1;
	logic signed [2*HW:0]   lh_s1;
	logic [2*HW-1:0]        ll_s1;
	nrd_pkg::prod_t         prod_s2;

	// The upper halves carry the sign; the lower halves are plain magnitudes.
	assign a_hi = $signed(a[nrd_pkg::FIX_W-1:HW]);
	assign b_hi = $signed(b[nrd_pkg::FIX_W-1:HW]);
	assign a_lo = $signed({1'b0, a[HW-1:0]});
	assign b_lo = $signed({1'b0, b[HW-1:0]});

	assign hh = (2*HW)'(a_hi) * (2*HW)'(b_hi);
	assign hl = (2*HW+1)'(a_hi) * (2*HW+1)'(b_lo);
	assign lh = (2*HW+1)'(a_lo) * (2*HW+1)'(b_hi);
	assign ll = (2*HW)'(a_lo) * (2*HW)'(b_lo);

	always_ff @(posedge clk) begin
		if (en.pp_en) begin
			hh_s1 <= hh;
			hl_s1 <= hl;
			lh_s1 <= lh;
			ll_s1 <= ll;
		end
		if (en.prod_en) begin
			prod_s2 <= {hh_s1, {(2*HW){1'b0}}}
				+ {{(HW-1){hl_s1[2*HW]}}, hl_s1, {HW{1'b0}}}
				+ {{(HW-1){lh_s1[2*HW]}}, lh_s1, {HW{1'b0}}}
				+ {{(2*HW){1'b0}}, ll_s1};
		end
	end

	assign prod = prod_s2;

endmodule

// ----- design/nrd_matrix.sv -----
// Free-running pipeline that builds the nutation matrix from the configuration registers.
module nrd_matrix (
	input  logic                            clk,
	input  logic [nrd_pkg::OBL_W-1:0]       cos_obl,
	input  logic [nrd_pkg::OBL_W-1:0]       sin_obl,
	input  logic signed [nrd_pkg::NUT_W-1:0] dpsi,
	input  logic signed [nrd_pkg::NUT_W-1:0] deps,
	output nrd_pkg::matrix_t                mat
);

	localparam nrd_pkg::mul_en_t RUN = '{pp_en: 1'b1, prod_en: 1'b1};
	localparam int unsigned SH  = nrd_pkg::FRAC_BITS;
	localparam int unsigned SH2 = nrd_pkg::FRAC_BITS + 1;

	nrd_pkg::fix_t    dpsi_x;
	nrd_pkg::fix_t    deps_x;
	nrd_pkg::fix_t    cos_x;
	nrd_pkg::fix_t    sin_x;
	nrd_pkg::prod_t   p_mu;
	nrd_pkg::prod_t   p_nu;
	nrd_pkg::prod_t   p_dd;
	nrd_pkg::prod_t   p_ee;
	nrd_pkg::prod_t   p_dn;
	nrd_pkg::prod_t   p_dm;
	nrd_pkg::prod_t   p_mm;
	nrd_pkg::prod_t   p_nn;
	nrd_pkg::prod_t   p_mn;
	nrd_pkg::fix_t    one_hee;
	nrd_pkg::narrow_t t_mn;

	nrd_pkg::fix_t    mu_s3;
	nrd_pkg::fix_t    nu_s3;
	nrd_pkg::fix_t    hdd_s3;
	nrd_pkg::fix_t    hee_s3;
	nrd_pkg::fix_t    dn_s6;
	nrd_pkg::fix_t    dm_s6;
	nrd_pkg::fix_t    mm_s6;
	nrd_pkg::fix_t    nn_s6;
	nrd_pkg::fix_t    mn_s6;
	nrd_pkg::matrix_t mat_s7;

	assign dpsi_x = nrd_pkg::fix_t'(dpsi);
	assign deps_x = nrd_pkg::fix_t'(deps);
	assign cos_x  = nrd_pkg::fix_t'(cos_obl);
	assign sin_x  = nrd_pkg::fix_t'(sin_obl);

	nrd_mul u_mul_mu (.clk(clk), .en(RUN), .a(dpsi_x), .b(cos_x),  .prod(p_mu));
	nrd_mul u_mul_nu (.clk(clk), .en(RUN), .a(dpsi_x), .b(sin_x),  .prod(p_nu));
	nrd_mul u_mul_dd (.clk(clk), .en(RUN), .a(dpsi_x), .b(dpsi_x), .prod(p_dd));
	nrd_mul u_mul_ee (.clk(clk), .en(RUN), .a(deps_x), .b(deps_x), .prod(p_ee));

	always_ff @(posedge clk) begin
		mu_s3  <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_mu), SH);
		nu_s3  <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_nu), SH);
		hdd_s3 <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_dd), SH2);
		hee_s3 <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_ee), SH2);
	end

	nrd_mul u_mul_dn (.clk(clk), .en(RUN), .a(deps_x), .b(nu_s3), .prod(p_dn));
	nrd_mul u_mul_dm (.clk(clk), .en(RUN), .a(deps_x), .b(mu_s3), .prod(p_dm));
	nrd_mul u_mul_mm (.clk(clk), .en(RUN), .a(mu_s3),  .b(mu_s3), .prod(p_mm));
	nrd_mul u_mul_nn (.clk(clk), .en(RUN), .a(nu_s3),  .b(nu_s3), .prod(p_nn));
	nrd_mul u_mul_mn (.clk(clk), .en(RUN), .a(mu_s3),  .b(nu_s3), .prod(p_mn));

	always_ff @(posedge clk) begin
		dn_s6 <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_dn), SH);
		dm_s6 <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_dm), SH);
		mm_s6 <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_mm), SH2);
		nn_s6 <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_nn), SH2);
		mn_s6 <= nrd_pkg::round_sat(nrd_pkg::acc_t'(p_mn), SH2);
	end

	// The second and third diagonal terms share one minus half the squared obliquity nutation.
	// The cross term is negated before clamping, so it needs the wider type.
	assign one_hee = nrd_pkg::sat_narrow(nrd_pkg::narrow_t'(nrd_pkg::ONE)
		- nrd_pkg::narrow_t'(hee_s3));
	assign t_mn = -nrd_pkg::narrow_t'(mn_s6);

	always_ff @(posedge clk) begin
		mat_s7.r0.c0 <= nrd_pkg::sat_narrow(nrd_pkg::narrow_t'(nrd_pkg::ONE)
			- nrd_pkg::narrow_t'(hdd_s3));
		mat_s7.r0.c1 <= nrd_pkg::sat_narrow(-nrd_pkg::narrow_t'(mu_s3));
		mat_s7.r0.c2 <= nrd_pkg::sat_narrow(-nrd_pkg::narrow_t'(nu_s3));
		mat_s7.r1.c0 <= nrd_pkg::sat_narrow(nrd_pkg::narrow_t'(mu_s3)
			- nrd_pkg::narrow_t'(dn_s6));
		mat_s7.r1.c1 <= nrd_pkg::sat_narrow(nrd_pkg::narrow_t'(one_hee)
			- nrd_pkg::narrow_t'(mm_s6));
		mat_s7.r1.c2 <= nrd_pkg::sat_narrow(t_mn - nrd_pkg::narrow_t'(deps_x));
		mat_s7.r2.c0 <= nrd_pkg::sat_narrow(nrd_pkg::narrow_t'(nu_s3)
			+ nrd_pkg::narrow_t'(dm_s6));
		mat_s7.r2.c1 <= nrd_pkg::sat_narrow(t_mn + nrd_pkg::narrow_t'(deps_x));
		mat_s7.r2.c2 <= nrd_pkg::sat_narrow(nrd_pkg::narrow_t'(one_hee)
			- nrd_pkg::narrow_t'(nn_s6));
	end

	assign mat = mat_s7;

endmodule

// ----- design/nrd_dot.sv -----
// Stalling row-by-vector dot product with a single rounding and clamp of the sum.
module nrd_dot (
	input  logic              clk,
	input  nrd_pkg::dot_en_t  en,
	input  nrd_pkg::row_t     row,
	input  nrd_pkg::vec_t     vec,
	output nrd_pkg::fix_t     res
);

	nrd_pkg::prod_t p0;
	nrd_pkg::prod_t p1;
	nrd_pkg::prod_t p2;
	nrd_pkg::acc_t  acc_s11;
	nrd_pkg::fix_t  res_s12;

	nrd_mul u_mul0 (.clk(clk), .en(en.mul), .a(row.c0), .b(vec.x), .prod(p0));
	nrd_mul u_mul1 (.clk(clk), .en(en.mul), .a(row.c1), .b(vec.y), .prod(p1));
	nrd_mul u_mul2 (.clk(clk), .en(en.mul), .a(row.c2), .b(vec.z), .prod(p2));

	// The rounding half is folded into the sum so the last stage is a shift and clamp.
	always_ff @(posedge clk) begin
		if (en.acc_en) begin
			acc_s11 <= nrd_pkg::acc_t'(p0) + nrd_pkg::acc_t'(p1) + nrd_pkg::acc_t'(p2)
				+ nrd_pkg::ROUND_HALF;
		end
		if (en.out_en) begin
			res_s12 <= nrd_pkg::sat_acc(acc_s11 >>> nrd_pkg::FRAC_BITS);
		end
	end

	assign res = res_s12;

endmodule

// ----- design/nutation_rotate_direction.sv -----
// Top level: configuration registers, item pipeline control and the three matrix rows.
//
// Turns a mean direction (mean_x/y/z, signed Q46) into the nutated true direction
// (true_x/y/z, signed Q46, clamped). Both channels move a transaction at a rising
// edge where valid is high and stall is low.
// Software writes the obliquity cosine and sine and the two nutation angles through
// cfg_wr_en/cfg_index/cfg_data while no transaction is in flight; a write takes
// effect for every item accepted at the same edge or later.
// The item path has twelve register stages. Throughput is one item per cycle
// while the receiver does not stall. The first eight stages carry the vector
// while the matrix pipeline (seven stages behind the configuration registers)
// settles; the dot product then takes a partial-product stage, a product stage,
// a sum stage and a rounding and clamp stage.
// Reset clears all valid bits and loads the registers with cosine one and zero
// sine and nutation. When the receiver stalls, the output holds and each stage
// keeps its item until the next one frees up, so empty stages still fill and
// mean_stall rises only once every stage holds an item.
module nutation_rotate_direction (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [nrd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [nrd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          mean_valid,
	output logic                          mean_stall,
	input  nrd_pkg::fix_t                 mean_x,
	input  nrd_pkg::fix_t                 mean_y,
	input  nrd_pkg::fix_t                 mean_z,
	output logic                          true_valid,
	input  logic                          true_stall,
	output nrd_pkg::fix_t                 true_x,
	output nrd_pkg::fix_t                 true_y,
	output nrd_pkg::fix_t                 true_z
);

	logic [nrd_pkg::OBL_W-1:0]        cos_q;
	logic [nrd_pkg::OBL_W-1:0]        sin_q;
	logic signed [nrd_pkg::NUT_W-1:0] dpsi_q;
	logic signed [nrd_pkg::NUT_W-1:0] deps_q;

	nrd_pkg::matrix_t mat;
	nrd_pkg::dot_en_t dot_en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic valid_s7, valid_s8, valid_s9, valid_s10, valid_s11, valid_s12;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic en_s7, en_s8, en_s9, en_s10, en_s11, en_s12;

	nrd_pkg::vec_t vec_s1, vec_s2, vec_s3, vec_s4, vec_s5, vec_s6, vec_s7, vec_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= nrd_pkg::COS_RESET;
			sin_q  <= '0;
			dpsi_q <= '0;
			deps_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (nrd_pkg::reg_idx_t'(cfg_index))
				nrd_pkg::REG_COS:  cos_q  <= cfg_data[nrd_pkg::OBL_W-1:0];
				nrd_pkg::REG_SIN:  sin_q  <= cfg_data[nrd_pkg::OBL_W-1:0];
				nrd_pkg::REG_DPSI: dpsi_q <= $signed(cfg_data[nrd_pkg::NUT_W-1:0]);
				nrd_pkg::REG_DEPS: deps_q <= $signed(cfg_data[nrd_pkg::NUT_W-1:0]);
				default: ;
			endcase
		end
	end

	nrd_matrix u_matrix (
		.clk     (clk),
		.cos_obl (cos_q),
		.sin_obl (sin_q),
		.dpsi    (dpsi_q),
		.deps    (deps_q),
		.mat     (mat)
	);

	// A stage may load when it is empty or when the stage after it moves on.
	assign en_s12 = !valid_s12 || !true_stall;
	assign en_s11 = !valid_s11 || en_s12;
	assign en_s10 = !valid_s10 || en_s11;
	assign en_s9  = !valid_s9  || en_s10;
	assign en_s8  = !valid_s8  || en_s9;
	assign en_s7  = !valid_s7  || en_s8;
	assign en_s6  = !valid_s6  || en_s7;
	assign en_s5  = !valid_s5  || en_s6;
	assign en_s4  = !valid_s4  || en_s5;
	assign en_s3  = !valid_s3  || en_s4;
	assign en_s2  = !valid_s2  || en_s3;
	assign en_s1  = !valid_s1  || en_s2;

	assign mean_stall = !en_s1;
	assign true_valid = valid_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			if (en_s1)  valid_s1  <= mean_valid;
			if (en_s2)  valid_s2  <= valid_s1;
			if (en_s3)  valid_s3  <= valid_s2;
			if (en_s4)  valid_s4  <= valid_s3;
			if (en_s5)  valid_s5  <= valid_s4;
			if (en_s6)  valid_s6  <= valid_s5;
			if (en_s7)  valid_s7  <= valid_s6;
			if (en_s8)  valid_s8  <= valid_s7;
			if (en_s9)  valid_s9  <= valid_s8;
			if (en_s10) valid_s10 <= valid_s9;
			if (en_s11) valid_s11 <= valid_s10;
			if (en_s12) valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			vec_s1.x <= mean_x;
			vec_s1.y <= mean_y;
			vec_s1.z <= mean_z;
		end
		if (en_s2) vec_s2 <= vec_s1;
		if (en_s3) vec_s3 <= vec_s2;
		if (en_s4) vec_s4 <= vec_s3;
		if (en_s5) vec_s5 <= vec_s4;
		if (en_s6) vec_s6 <= vec_s5;
		if (en_s7) vec_s7 <= vec_s6;
		if (en_s8) vec_s8 <= vec_s7;
	end

	assign dot_en = '{
		mul:    '{pp_en: en_s9, prod_en: en_s10},
		acc_en: en_s11,
		out_en: en_s12
	};

	nrd_dot u_dot_x (.clk(clk), .en(dot_en), .row(mat.r0), .vec(vec_s8), .res(true_x));
	nrd_dot u_dot_y (.clk(clk), .en(dot_en), .row(mat.r1), .vec(vec_s8), .res(true_y));
	nrd_dot u_dot_z (.clk(clk), .en(dot_en), .row(mat.r2), .vec(vec_s8), .res(true_z));

endmodule
